// ===== design/vln_pkg.sv =====
// ----------------------------------------------------------------------------
// vln_pkg
// Shared types and constants for the vector length and normalize pipeline.
// ----------------------------------------------------------------------------
package vln_pkg;

  localparam int COMP_W  = 32;
  localparam int SUM_W   = 64;
  localparam int UNIT_FRAC = 16;
  localparam int QUO_W   = UNIT_FRAC + 1;
  localparam int UNIT_W  = UNIT_FRAC + 2;
  localparam int DIVD_W  = COMP_W + UNIT_FRAC + 1;
  localparam int SQRT_STEPS = SUM_W / 2;

  typedef struct packed {
    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] my;
    logic [COMP_W-1:0] mz;
    logic              nx;
    logic              ny;
    logic              nz;
  } mag_t;

  typedef struct packed {
    mag_t             m;
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [COMP_W-1:0] len;
    logic [DIVD_W-1:0] rx;
    logic [DIVD_W-1:0] ry;
    logic [DIVD_W-1:0] rz;
    logic [QUO_W-1:0]  qx;
    logic [QUO_W-1:0]  qy;
    logic [QUO_W-1:0]  qz;
    logic              nx;
    logic              ny;
    logic              nz;
  } div_t;

endpackage

// ===== design/vln_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// vln_sqrt_stage
// One step of the digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module vln_sqrt_stage import vln_pkg::*; #(
  parameter int BIT_POS = 62
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  sqrt_t in_data,
  output logic  out_valid,
  output sqrt_t out_data
);

  logic [SUM_W-1:0] bit_val;
  logic [SUM_W-1:0] trial;
  sqrt_t            data_next;

  assign bit_val = SUM_W'(1) << BIT_POS;
  assign trial   = in_data.res + bit_val;

  always_comb begin
    data_next = in_data;
    if (in_data.rem >= trial) begin
      data_next.rem = in_data.rem - trial;
      data_next.res = (in_data.res >> 1) + bit_val;
    end else begin
      data_next.res = in_data.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/vln_div_stage.sv =====
// ----------------------------------------------------------------------------
// vln_div_stage
// One quotient bit of restoring division for all three lanes, registered.
// ----------------------------------------------------------------------------
module vln_div_stage import vln_pkg::*; #(
  parameter int QBIT = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic [DIVD_W-1:0] dsor;
  div_t              data_next;

  assign dsor = DIVD_W'(in_data.len) << QBIT;

  always_comb begin
    data_next = in_data;
    if (in_data.rx >= dsor) begin
      data_next.rx       = in_data.rx - dsor;
      data_next.qx[QBIT] = 1'b1;
    end
    if (in_data.ry >= dsor) begin
      data_next.ry       = in_data.ry - dsor;
      data_next.qy[QBIT] = 1'b1;
    end
    if (in_data.rz >= dsor) begin
      data_next.rz       = in_data.rz - dsor;
      data_next.qz[QBIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/vector3_length_normalize.sv =====
// ----------------------------------------------------------------------------
// vector3_length_normalize
// Length and unit vector of a 3D fixed-point vector, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with comp_x, comp_y, comp_z (Q16.16).
// Output channel: out_valid/out_stall with length (Q16.16, truncated square
// root), unit_x/y/z (Q1.16, truncated toward zero) and zero_length.
// A zero vector gives a zero unit vector with zero_length set.
// Throughput: one item per cycle while no result waits on out_stall. Path from
// acceptance to out_valid: a register each for magnitude, squares and sum, 32 square root
// stages (one result bit each), 17 division stages (one quotient bit each
// for the three lanes) and the output register.
// Reset clears every valid bit; items in flight are dropped.
// When out_stall holds a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vector3_length_normalize import vln_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COMP_W-1:0] comp_x,
  input  logic signed [COMP_W-1:0] comp_y,
  input  logic signed [COMP_W-1:0] comp_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [COMP_W-1:0] length,
  output logic signed [UNIT_W-1:0] unit_x,
  output logic signed [UNIT_W-1:0] unit_y,
  output logic signed [UNIT_W-1:0] unit_z,
  output logic                     zero_length
);

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  mag_t             mag0;
  logic             v0;
  mag_t             mag1;
  logic [SUM_W-1:0] sqx, sqy, sqz;
  logic             v1;
  sqrt_t            sq_d [0:SQRT_STEPS];
  logic             sq_v [0:SQRT_STEPS];
  div_t             dv_d [0:QUO_W];
  logic             dv_v [0:QUO_W];

  function automatic logic [COMP_W-1:0] mag_of(input logic [COMP_W-1:0] v);
    mag_of = v[COMP_W-1] ? (~v + COMP_W'(1)) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      sq_v[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag0.mx <= mag_of(comp_x);
      mag0.my <= mag_of(comp_y);
      mag0.mz <= mag_of(comp_z);
      mag0.nx <= comp_x[COMP_W-1];
      mag0.ny <= comp_y[COMP_W-1];
      mag0.nz <= comp_z[COMP_W-1];
      mag1 <= mag0;
      sqx  <= SUM_W'(mag0.mx) * SUM_W'(mag0.mx);
      sqy  <= SUM_W'(mag0.my) * SUM_W'(mag0.my);
      sqz  <= SUM_W'(mag0.mz) * SUM_W'(mag0.mz);
      sq_d[0].m   <= mag1;
      sq_d[0].rem <= sqx + sqy + sqz;
      sq_d[0].res <= '0;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    vln_sqrt_stage #(.BIT_POS(SUM_W - 2 - 2 * i)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (sq_v[i]),
      .in_data  (sq_d[i]),
      .out_valid(sq_v[i+1]),
      .out_data (sq_d[i+1])
    );
  end

  always_comb begin
    dv_v[0]    = sq_v[SQRT_STEPS];
    dv_d[0].len = sq_d[SQRT_STEPS].res[COMP_W-1:0];
    dv_d[0].rx = DIVD_W'(sq_d[SQRT_STEPS].m.mx) << UNIT_FRAC;
    dv_d[0].ry = DIVD_W'(sq_d[SQRT_STEPS].m.my) << UNIT_FRAC;
    dv_d[0].rz = DIVD_W'(sq_d[SQRT_STEPS].m.mz) << UNIT_FRAC;
    dv_d[0].qx = '0;
    dv_d[0].qy = '0;
    dv_d[0].qz = '0;
    dv_d[0].nx = sq_d[SQRT_STEPS].m.nx;
    dv_d[0].ny = sq_d[SQRT_STEPS].m.ny;
    dv_d[0].nz = sq_d[SQRT_STEPS].m.nz;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    vln_div_stage #(.QBIT(QUO_W - 1 - k)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (dv_v[k]),
      .in_data  (dv_d[k]),
      .out_valid(dv_v[k+1]),
      .out_data (dv_d[k+1])
    );
  end

  function automatic logic [UNIT_W-1:0] signed_q(input logic [QUO_W-1:0] q,
                                                  input logic neg,
                                                  input logic zero);
    logic [UNIT_W-1:0] e;
    e = UNIT_W'(q);
    if (zero) signed_q = '0;
    else if (neg) signed_q = ~e + UNIT_W'(1);
    else signed_q = e;
  endfunction

  logic zl;
  assign zl = (dv_d[QUO_W].len == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      length      <= dv_d[QUO_W].len;
      unit_x      <= signed_q(dv_d[QUO_W].qx, dv_d[QUO_W].nx, zl);
      unit_y      <= signed_q(dv_d[QUO_W].qy, dv_d[QUO_W].ny, zl);
      unit_z      <= signed_q(dv_d[QUO_W].qz, dv_d[QUO_W].nz, zl);
      zero_length <= zl;
    end
  end

endmodule

// ===== dv/vln_checker.sv =====
// ----------------------------------------------------------------------------
// vln_checker
// Watches both channels of the vector length and normalize block, predicts
// length, unit vector and zero flag for each accepted vector, and compares
// each result with the oldest prediction.
// ----------------------------------------------------------------------------
module vln_checker import vln_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [COMP_W-1:0] comp_x,
  input  logic signed [COMP_W-1:0] comp_y,
  input  logic signed [COMP_W-1:0] comp_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic        [COMP_W-1:0] length,
  input  logic signed [UNIT_W-1:0] unit_x,
  input  logic signed [UNIT_W-1:0] unit_y,
  input  logic signed [UNIT_W-1:0] unit_z,
  input  logic                     zero_length,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [COMP_W-1:0] len;
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
    logic [UNIT_W-1:0] uz;
    logic              zl;
  } norm_t;

  norm_t norm_q[$];

  function automatic logic [63:0] mag_of(logic [COMP_W-1:0] c);
    logic [63:0] m;
    m = {32'd0, c};
    if (c[COMP_W-1]) m = {32'd0, -c};
    return m;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [UNIT_W-1:0] unit_of(logic [COMP_W-1:0] c, logic [63:0] len);
    logic [63:0] q;
    if (len == 0) return '0;
    q = (mag_of(c) << UNIT_FRAC) / len;
    if (c[COMP_W-1]) q = -q;
    return q[UNIT_W-1:0];
  endfunction

  function automatic norm_t predict_norm(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                                         logic [COMP_W-1:0] z);
    norm_t n;
    logic [63:0] mx, my, mz, len;
    mx = mag_of(x);
    my = mag_of(y);
    mz = mag_of(z);
    len = root_floor(mx * mx + my * my + mz * mz);
    n.len = len[COMP_W-1:0];
    n.ux = unit_of(x, len);
    n.uy = unit_of(y, len);
    n.uz = unit_of(z, len);
    n.zl = (len == 0);
    return n;
  endfunction

  assign pending = norm_q.size();

  always @(posedge clk) begin
    norm_t e;
    norm_t a;
    if (rst) begin
      fail_count <= 0;
      norm_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        a = {length, unit_x, unit_y, unit_z, zero_length};
        if (norm_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, a);
          fail_count <= fail_count + 1;
        end else begin
          e = norm_q.pop_front();
          if (e != a) begin
            $display("%0t: mismatch len/ux/uy/uz/zl expected %h %h %h %h %b actual %h %h %h %h %b",
                     $time, e.len, e.ux, e.uy, e.uz, e.zl, a.len, a.ux, a.uy, a.uz, a.zl);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) norm_q.push_back(predict_norm(comp_x, comp_y, comp_z));
    end
  end

endmodule

// ===== dv/tb_vector3_length_normalize.sv =====
// ----------------------------------------------------------------------------
// tb_vector3_length_normalize
// Drives directed and random vectors through the length and normalize block
// under several idle and stall patterns and reports the verdict.
// ----------------------------------------------------------------------------
module tb_vector3_length_normalize import vln_pkg::*; ();

  localparam int LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [COMP_W-1:0] comp_x = 0, comp_y = 0, comp_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [COMP_W-1:0] length;
  logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
  logic zero_length;
  int fail_count, pending;
  int idle_pct = 0, stall_pct = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  vector3_length_normalize dut (.*);
  vln_checker chk (.*);

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    comp_x <= x;
    comp_y <= y;
    comp_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(255) - 128;
      2: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'(($urandom))};
      3: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff) ^ $urandom_range(3);
      4: return 0;
      default: return 32'(signed'($urandom_range(65536 * 8))) * ($urandom_range(1) ? 1 : -1);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int pct[4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{25, 25}};
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_vec(0, 0, 0);
    send_vec(1, 1, 1);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vec(32'h8000_0000, 0, 0);
    send_vec(0, 32'h7fff_ffff, 0);
    send_vec(0, 0, 32'hffff_ffff);
    send_vec(32'h0001_0000, 32'hffff_0000, 0);
    send_vec(3, 4, 0);
    send_vec(-3, 0, -4);
    send_vec(1, 0, 0);
    send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vec(32'h0003_0000, 32'h0004_0000, 32'h000c_0000);
    send_vec(32'h7fff_ffff, 32'h8000_0000, 1);
    drain();
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p][0];
      stall_pct = pct[p][1];
      for (int i = 0; i < 470; i++) send_vec(rand_comp(), rand_comp(), rand_comp());
      drain();
    end
    stall_pct = 0;
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== vector3_length_normalize.f =====
design/vln_pkg.sv
design/vln_sqrt_stage.sv
design/vln_div_stage.sv
design/vector3_length_normalize.sv
dv/vln_checker.sv
dv/tb_vector3_length_normalize.sv
